>>> rtl/dsol_pkg.sv
// Shared types and constants for the differential speed order limiter.
// Used by dsol_ctrl, dsol_dp and the top level; depends on nothing else.
package dsol_pkg;

  // Fixed point layout of speeds
  localparam int FRAC_BITS = 16;
  localparam int SPD_W     = 32;             // signed speed width
  localparam int REG_W     = 31;             // config register width
  localparam int WIN_W     = SPD_W + 2;      // step window bounds, never wrap
  localparam int PROD_W    = 2 * REG_W;      // |lin| * |ang|
  localparam int DIV_W     = REG_W + FRAC_BITS;  // product_limit << FRAC_BITS
  localparam int Q_W       = REG_W;          // quotient always below |lin|
  localparam int CNT_W     = $clog2(Q_W);
  localparam int IDX_W     = 3;

  // Reset values of the config registers
  localparam logic [REG_W-1:0] LIN_LIMIT_RST  = REG_W'(65536);
  localparam logic [REG_W-1:0] ANG_LIMIT_RST  = REG_W'(65536);
  localparam logic [REG_W-1:0] LIN_STEP_RST   = REG_W'(655);
  localparam logic [REG_W-1:0] ANG_STEP_RST   = REG_W'(655);
  localparam logic [REG_W-1:0] PROD_LIMIT_RST = REG_W'(65536);

  // Config register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_LIN_LIMIT  = 3'd0,
    REG_ANG_LIMIT  = 3'd1,
    REG_LIN_STEP   = 3'd2,
    REG_ANG_STEP   = 3'd3,
    REG_PROD_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] lin_limit;
    logic [REG_W-1:0] ang_limit;
    logic [REG_W-1:0] lin_step;
    logic [REG_W-1:0] ang_step;
    logic [REG_W-1:0] prod_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic clamp;
    logic mul;
    logic cmp;
    logic div_init;
    logic div_step;
    logic fix;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic limit_hit;
    logic div_last;
  } sts_t;

endpackage

>>> rtl/differential_speed_order_limiter.sv
// Top level of the differential speed order limiter.
// Holds the config registers; instantiates dsol_ctrl and dsol_dp (dsol_pkg).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one control tick: a requested
//   linear and angular speed, signed Q16.16. The output channel
//   (out_valid/out_ready) returns the constrained pair and product_limited.
//   Config registers are written through cfg_write/cfg_index/cfg_data while
//   the block is idle; unknown indexes are ignored.
//   The result passes through the states CLAMP, MUL, CMP and DONE after the
//   accepting edge, with the serial divider (DIV) and FIX between CMP and
//   DONE when the product limit applies. One item is in flight at a time, so
//   a new item is taken only once the last one is in the output register.
//   A finished result sits in the output register while the next item is
//   accepted and processed; if the receiver still stalls when that item
//   finishes, the block waits and holds in_ready low.
//   Reset (rst, synchronous) clears the last speed pair to zero, drops any
//   pending item and restores the register defaults.
module differential_speed_order_limiter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dsol_pkg::IDX_W-1:0]        cfg_index,
  input  logic [dsol_pkg::REG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dsol_pkg::SPD_W-1:0] linear_request,
  input  logic signed [dsol_pkg::SPD_W-1:0] angular_request,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dsol_pkg::SPD_W-1:0] linear_command,
  output logic signed [dsol_pkg::SPD_W-1:0] angular_command,
  output logic                              product_limited
);
  import dsol_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lin_limit  <= LIN_LIMIT_RST;
      cfg.ang_limit  <= ANG_LIMIT_RST;
      cfg.lin_step   <= LIN_STEP_RST;
      cfg.ang_step   <= ANG_STEP_RST;
      cfg.prod_limit <= PROD_LIMIT_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_LIN_LIMIT:  cfg.lin_limit  <= cfg_data;
        REG_ANG_LIMIT:  cfg.ang_limit  <= cfg_data;
        REG_LIN_STEP:   cfg.lin_step   <= cfg_data;
        REG_ANG_STEP:   cfg.ang_step   <= cfg_data;
        REG_PROD_LIMIT: cfg.prod_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  dsol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dsol_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .linear_request  (linear_request),
    .angular_request (angular_request),
    .linear_command  (linear_command),
    .angular_command (angular_command),
    .product_limited (product_limited)
  );

endmodule

>>> rtl/dsol_ctrl.sv
// Sequencer for the speed order limiter: handshakes and datapath commands.
// Depends on dsol_pkg.
module dsol_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dsol_pkg::sts_t sts,
  output dsol_pkg::cmd_t cmd
);
  import dsol_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.limit_hit) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the item is taken
  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

>>> rtl/dsol_dp.sv
// Datapath for the speed order limiter: step windows, speed clamps,
// product test, serial restoring divider and output registers. Uses dsol_pkg.
module dsol_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  dsol_pkg::cfg_t               cfg,
  input  dsol_pkg::cmd_t               cmd,
  output dsol_pkg::sts_t               sts,
  input  logic signed [dsol_pkg::SPD_W-1:0] linear_request,
  input  logic signed [dsol_pkg::SPD_W-1:0] angular_request,
  output logic signed [dsol_pkg::SPD_W-1:0] linear_command,
  output logic signed [dsol_pkg::SPD_W-1:0] angular_command,
  output logic                         product_limited
);
  import dsol_pkg::*;

  function automatic logic signed [WIN_W-1:0] ext_s(input logic signed [SPD_W-1:0] x);
    ext_s = WIN_W'(x);
  endfunction

  function automatic logic signed [WIN_W-1:0] ext_u(input logic [REG_W-1:0] x);
    ext_u = $signed({{(WIN_W-REG_W){1'b0}}, x});
  endfunction

  function automatic logic signed [WIN_W-1:0] clampw(input logic signed [WIN_W-1:0] x,
                                                     input logic signed [WIN_W-1:0] lo,
                                                     input logic signed [WIN_W-1:0] hi);
    if (x < lo) clampw = lo;
    else if (x > hi) clampw = hi;
    else clampw = x;
  endfunction

  logic signed [SPD_W-1:0]  req_l, req_a, lin, ang, last_l, last_a;
  logic signed [WIN_W-1:0]  lo_l, hi_l;
  logic signed [WIN_W-1:0]  lo_l_c, hi_l_c, lo_a_c, hi_a_c, lin_c, ang_c, lin_w;
  logic signed [WIN_W-1:0]  q_s, repl_c, fix_c;
  logic [REG_W-1:0]         alin, aang, alin_c, aang_c;
  logic [PROD_W-1:0]        product;
  logic [DIV_W-1:0]         dividend;
  logic [REG_W-1:0]         rem;
  logic [Q_W-1:0]           dq;
  logic [CNT_W-1:0]         cnt;
  logic [REG_W:0]           trial;
  logic [REG_W+1:0]         diff;
  logic                     ge;
  logic                     limited, out_lim;

  // Step windows and clamps
  always_comb begin
    lo_l_c = ext_s(last_l) - ext_u(cfg.lin_step);
    hi_l_c = ext_s(last_l) + ext_u(cfg.lin_step);
    lo_a_c = ext_s(last_a) - ext_u(cfg.ang_step);
    hi_a_c = ext_s(last_a) + ext_u(cfg.ang_step);
    lin_c  = clampw(clampw(ext_s(req_l), lo_l_c, hi_l_c),
                    -ext_u(cfg.lin_limit), ext_u(cfg.lin_limit));
    ang_c  = clampw(clampw(ext_s(req_a), lo_a_c, hi_a_c),
                    -ext_u(cfg.ang_limit), ext_u(cfg.ang_limit));
    lin_w  = ext_s(lin);
  end

  // Magnitudes; clamped speeds never reach -2^31
  assign alin_c = (lin < 0) ? REG_W'(-lin) : REG_W'(lin);
  assign aang_c = (ang < 0) ? REG_W'(-ang) : REG_W'(ang);

  // Product test against product_limit in Q.2F
  assign dividend      = {cfg.prod_limit, {FRAC_BITS{1'b0}}};
  assign sts.limit_hit = (aang != '0) && (product > PROD_W'(dividend));
  assign sts.div_last  = (cnt == CNT_W'(Q_W - 1));

  // One restoring division step
  always_comb begin
    trial = {rem, dq[Q_W-1]};
    diff  = {1'b0, trial} - {2'b00, aang};
    ge    = !diff[REG_W+1];
  end

  // Replacement speed, signed and held to the linear window
  always_comb begin
    q_s    = $signed({{(WIN_W-Q_W){1'b0}}, dq});
    repl_c = (lin > 0) ? q_s : -q_s;
    fix_c  = clampw(repl_c, lo_l, hi_l);
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_l <= linear_request;
      req_a <= angular_request;
    end
    if (cmd.clamp) begin
      lin  <= lin_c[SPD_W-1:0];
      ang  <= ang_c[SPD_W-1:0];
      lo_l <= lo_l_c;
      hi_l <= hi_l_c;
    end
    if (cmd.mul) begin
      alin    <= alin_c;
      aang    <= aang_c;
      product <= alin_c * aang_c;
    end
    if (cmd.cmp) limited <= sts.limit_hit;
    if (cmd.div_init) begin
      rem <= REG_W'(dividend[DIV_W-1:Q_W]);
      dq  <= dividend[Q_W-1:0];
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
      dq  <= {dq[Q_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
    if (cmd.fix) lin <= fix_c[SPD_W-1:0];
    if (cmd.load_out) out_lim <= limited;
  end

  // Last constrained pair, also the output payload
  always_ff @(posedge clk) begin
    if (rst) begin
      last_l <= '0;
      last_a <= '0;
    end else if (cmd.load_out) begin
      last_l <= lin;
      last_a <= ang;
    end
  end

  assign linear_command  = last_l;
  assign angular_command = last_a;
  assign product_limited = out_lim;

  // Divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> aang != '0)
    else $error("divider stepped with zero divisor");

  // Replacement quotient stays below the clamped magnitude
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |-> dq < alin)
    else $error("quotient not below linear magnitude");

  // Replaced linear speed lies in its step window
  a_fix_window: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |=> (lin_w >= lo_l && lin_w <= hi_l))
    else $error("replaced linear speed outside step window");

endmodule

>>> bench/testbench.sv
// Self-checking bench for differential_speed_order_limiter: random and directed speed requests.
// Holds its own predictor of the rate and product limits; depends on dsol_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import dsol_pkg::*;

  localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};
  localparam logic [REG_W-1:0]        REG_MAX = '1;
  localparam int                      SECTIONS = 8;
  localparam int                      SECTION_ITEMS = 50;

  typedef struct packed {
    logic signed [SPD_W-1:0] lin;
    logic signed [SPD_W-1:0] ang;
    logic                    limited;
  } command_t;

  // Predicts constrained speed pairs and checks them against the block
  class command_tracker;
    logic [REG_W-1:0]        lin_limit, ang_limit, lin_step, ang_step, prod_limit;
    logic signed [SPD_W-1:0] last_lin, last_ang;
    command_t                pending_commands[$];
    int                      failures;

    function new();
      lin_limit  = LIN_LIMIT_RST;
      ang_limit  = ANG_LIMIT_RST;
      lin_step   = LIN_STEP_RST;
      ang_step   = ANG_STEP_RST;
      prod_limit = PROD_LIMIT_RST;
      last_lin   = '0;
      last_ang   = '0;
      failures   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        REG_LIN_LIMIT:  lin_limit = val;
        REG_ANG_LIMIT:  ang_limit = val;
        REG_LIN_STEP:   lin_step = val;
        REG_ANG_STEP:   ang_step = val;
        REG_PROD_LIMIT: prod_limit = val;
        default: ;  // unknown index, ignored
      endcase
    endfunction

    function longint bound(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    // Work out the command for one accepted request and queue it
    function void note_request(logic signed [SPD_W-1:0] lin_req,
                               logic signed [SPD_W-1:0] ang_req);
      longint          lo_l, hi_l, lo_a, hi_a, lin, ang, repl;
      longint unsigned alin, aang, cap, quo;
      command_t        cmd;
      lo_l = longint'(last_lin) - longint'(lin_step);
      hi_l = longint'(last_lin) + longint'(lin_step);
      lo_a = longint'(last_ang) - longint'(ang_step);
      hi_a = longint'(last_ang) + longint'(ang_step);
      lin = bound(longint'(lin_req), lo_l, hi_l);
      lin = bound(lin, -longint'(lin_limit), longint'(lin_limit));
      ang = bound(longint'(ang_req), lo_a, hi_a);
      ang = bound(ang, -longint'(ang_limit), longint'(ang_limit));
      alin = (lin < 0) ? longint'(-lin) : lin;
      aang = (ang < 0) ? longint'(-ang) : ang;
      cap = prod_limit;
      cap = cap << FRAC_BITS;
      cmd.limited = 1'b0;
      // product rule: angular wins, linear becomes limit / |angular|
      if (aang != 0 && alin * aang > cap) begin
        quo = cap / aang;
        if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
        repl = (lin > 0) ? longint'(quo) : -longint'(quo);
        lin = bound(repl, lo_l, hi_l);
        cmd.limited = 1'b1;
      end
      last_lin = lin[SPD_W-1:0];
      last_ang = ang[SPD_W-1:0];
      cmd.lin = last_lin;
      cmd.ang = last_ang;
      pending_commands.push_back(cmd);
    endfunction

    function void check_command(logic signed [SPD_W-1:0] lin_cmd,
                                logic signed [SPD_W-1:0] ang_cmd, logic limited);
      command_t want;
      if (pending_commands.size() == 0) begin
        $error("output item with no request waiting");
        failures++;
        return;
      end
      want = pending_commands.pop_front();
      if (lin_cmd !== want.lin) begin
        $error("linear_command: expected %0d, got %0d", want.lin, lin_cmd);
        failures++;
      end
      if (ang_cmd !== want.ang) begin
        $error("angular_command: expected %0d, got %0d", want.ang, ang_cmd);
        failures++;
      end
      if (limited !== want.limited) begin
        $error("product_limited: expected %0d, got %0d", want.limited, limited);
        failures++;
      end
    endfunction

    function int pending();
      return pending_commands.size();
    endfunction

    function void finish_check();
      if (pending_commands.size() != 0) begin
        $error("%0d expected output items never arrived", pending_commands.size());
        failures++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [REG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [SPD_W-1:0] linear_request = '0;
  logic signed [SPD_W-1:0] angular_request = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SPD_W-1:0] linear_command;
  logic signed [SPD_W-1:0] angular_command;
  logic                    product_limited;

  command_tracker tracker;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  differential_speed_order_limiter dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .linear_request  (linear_request),
    .angular_request (angular_request),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .linear_command  (linear_command),
    .angular_command (angular_command),
    .product_limited (product_limited)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Handshake monitors
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      tracker.note_request(linear_request, angular_request);
    if (!rst && out_valid && out_ready)
      tracker.check_command(linear_command, angular_command, product_limited);
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Full register set, plus one write to an unused index
  task automatic load_config(logic [REG_W-1:0] lin_lim, logic [REG_W-1:0] ang_lim,
                             logic [REG_W-1:0] lin_st, logic [REG_W-1:0] ang_st,
                             logic [REG_W-1:0] prod);
    logic [IDX_W-1:0] spare;
    spare = IDX_W'(REG_PROD_LIMIT) + IDX_W'($urandom_range(1, 3));
    write_reg(REG_LIN_LIMIT, lin_lim);
    write_reg(REG_ANG_LIMIT, ang_lim);
    write_reg(REG_LIN_STEP, lin_st);
    write_reg(REG_ANG_STEP, ang_st);
    write_reg(REG_PROD_LIMIT, prod);
    write_reg(spare, REG_W'($urandom()));
    cfg_write <= 1'b0;
  endtask

  task automatic send_request(logic signed [SPD_W-1:0] lin_req,
                              logic signed [SPD_W-1:0] ang_req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    linear_request  <= lin_req;
    angular_request <= ang_req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every command has come back
  task automatic drain();
    in_valid <= 1'b0;
    // advance the clock first, so the monitor has noted the last accepted item
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_limit();
    case ($urandom_range(6))
      0: return '0;
      1: return REG_MAX;
      2: return REG_W'($urandom_range(4096));
      3, 4: return REG_W'($urandom_range(1 << 20));
      5: return REG_W'($urandom_range(1 << 24));
      default: return REG_W'($urandom());
    endcase
  endfunction

  // Mostly requests around the last command, so the step window matters
  function automatic logic signed [SPD_W-1:0] pick_request(logic signed [SPD_W-1:0] last,
                                                           logic [REG_W-1:0] step);
    longint off, v;
    case ($urandom_range(9))
      0, 1, 2: return SPD_W'($urandom());
      3, 4, 5, 6: begin
        off = longint'(step) >> $urandom_range(2);
        off = off + longint'($urandom_range(8)) - 4;
        if ($urandom_range(1)) off = -off;
        v = longint'(last) + off;
        if (v > longint'(SPD_MAX)) v = longint'(SPD_MAX);
        if (v < longint'(SPD_MIN)) v = longint'(SPD_MIN);
        return v[SPD_W-1:0];
      end
      7: begin
        case ($urandom_range(3))
          0: return SPD_MAX;
          1: return SPD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return SPD_W'(int'($urandom_range(1 << 18)) - (1 << 17));
    endcase
  endfunction

  initial begin
    int send_plan[4];
    int recv_plan[4];
    send_plan = '{0, 50, 0, 38};
    recv_plan = '{0, 0, 50, 38};
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: small steps, unit limits
    send_request(SPD_MAX, SPD_MAX);
    send_request(SPD_MIN, SPD_MIN);
    send_request('0, '0);
    send_request(32'sd1, -32'sd1);
    send_request(-32'sd1, 32'sd1);
    drain();

    // Wide open limits, product limit of one: exact boundary, just over, sign kept
    load_config(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_W'(65536));
    send_request(32'sd131072, 32'sd32768);
    send_request(32'sd131073, 32'sd32768);
    send_request(-32'sd131073, 32'sd32768);
    send_request(SPD_MAX, '0);
    send_request(SPD_MAX, SPD_MAX);
    send_request(SPD_MIN, SPD_MIN);
    send_request('0, SPD_MIN);
    drain();

    // Slow linear ramp: the replaced speed is held to the step window
    load_config(REG_MAX, REG_MAX, REG_W'(1000), REG_MAX, REG_W'(65536));
    send_request(-32'sd1048576, 32'sd1048576);
    send_request(SPD_MAX, SPD_MIN);
    send_request(SPD_MIN, SPD_MAX);
    drain();

    // Zero product limit: any motion with turning forces linear to zero
    load_config(REG_MAX, REG_MAX, REG_MAX, REG_MAX, '0);
    send_request(32'sd327680, 32'sd3);
    send_request(-32'sd327680, -32'sd3);
    send_request(SPD_MIN, '0);
    drain();

    // Everything zero
    load_config('0, '0, '0, '0, '0);
    send_request(SPD_MAX, SPD_MIN);
    send_request(SPD_MIN, SPD_MAX);

    // Random sections over the idle plans
    for (int s = 0; s < SECTIONS; s++) begin
      drain();
      load_config(pick_limit(), pick_limit(), pick_limit(), pick_limit(), pick_limit());
      send_idle_pct  = send_plan[s % 4];
      recv_stall_pct = recv_plan[s % 4];
      for (int i = 0; i < SECTION_ITEMS; i++)
        send_request(pick_request(tracker.last_lin, tracker.lin_step),
                     pick_request(tracker.last_ang, tracker.ang_step));
    end

    drain();
    repeat (40) @(posedge clk);
    tracker.finish_check();
    if (tracker.failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
